// ----- design/pwm_mask_run_burst_writer_defines.svh -----
// Assertion macros shared by the block's modules.
// Each expects a clock named clk and an active-high reset named rst in scope.
`ifndef PWM_MASK_RUN_BURST_WRITER_DEFINES_SVH
`define PWM_MASK_RUN_BURST_WRITER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PMRBW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pmrbw same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PMRBW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pmrbw next-cycle check failed");

`endif

// ----- design/pmrbw_pkg.sv -----
`timescale 1ns / 1ps
package pmrbw_pkg;

  // Field widths
  localparam int MASK_W  = 16;
  localparam int DUTY_W  = 16;
  localparam int ADDR_W  = 7;
  localparam int REG_W   = 7;
  localparam int FIRST_W = 4;
  localparam int RUN_W   = 5;
  localparam int BYTES_W = 7;
  localparam int COUNT_W = 13;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_BUS_ADDR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd1;
  localparam logic [ADDR_W-1:0]    BUS_ADDR_RST   = 7'd64;
  localparam logic [COUNT_W-1:0]   FULL_SCALE_RST = 13'd4096;

  // Duty codes and register map
  localparam logic [DUTY_W-1:0] DUTY_FULL_ON  = 16'hFFFF;
  localparam logic [DUTY_W-1:0] DUTY_FULL_OFF = 16'h0000;
  localparam logic [REG_W-1:0]  FIRST_LED_REG = 7'd6;

  localparam int CHANNELS_DEF = 16;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic load_nonzero;
    logic run_last;
  } dp_status_t;

  // One burst descriptor
  typedef struct packed {
    logic [ADDR_W-1:0]  target_address;
    logic [REG_W-1:0]   start_register;
    logic [FIRST_W-1:0] first_channel;
    logic [RUN_W-1:0]   run_length;
    logic [BYTES_W-1:0] byte_count;
    logic [COUNT_W-1:0] on_count;
    logic [COUNT_W-1:0] off_count;
    logic               last_burst;
  } burst_t;

endpackage

// ----- design/pmrbw_ifs.sv -----
`timescale 1ns / 1ps
interface pmrbw_item_if
  import pmrbw_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] channel_mask;
  logic [DUTY_W-1:0] duty_value;
  modport source (output valid, channel_mask, duty_value, input ready);
  modport sink (input valid, channel_mask, duty_value, output ready);
endinterface

interface pmrbw_burst_if
  import pmrbw_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  target_address;
  logic [REG_W-1:0]   start_register;
  logic [FIRST_W-1:0] first_channel;
  logic [RUN_W-1:0]   run_length;
  logic [BYTES_W-1:0] byte_count;
  logic [COUNT_W-1:0] on_count;
  logic [COUNT_W-1:0] off_count;
  logic               last_burst;
  modport source (output valid, target_address, start_register, first_channel,
                  run_length, byte_count, on_count, off_count, last_burst,
                  input ready);
  modport sink (input valid, target_address, start_register, first_channel,
                run_length, byte_count, on_count, off_count, last_burst,
                output ready);
endinterface

interface pmrbw_cfg_if
  import pmrbw_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/pmrbw_ctrl.sv -----
`timescale 1ns / 1ps
`include "pwm_mask_run_burst_writer_defines.svh"
module pmrbw_ctrl
  import pmrbw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic       burst_ready,
  output logic       burst_valid,
  output ctrl_cmd_t  cmd,
  input  dp_status_t sts
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;
  logic burst_valid_next;

  // Take a request only while no mask is being split
  assign item_ready = (state == ST_IDLE);
  assign cmd.load   = item_valid && item_ready;
  // Emit one descriptor per cycle while the output register frees up
  assign cmd.emit   = (state == ST_RUN) && (!burst_valid || burst_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load && sts.load_nonzero) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.emit && sts.run_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold the descriptor until taken, refill on emit
  always_comb begin
    burst_valid_next = burst_valid;
    if (cmd.emit) burst_valid_next = 1'b1;
    else if (burst_ready) burst_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      burst_valid <= 1'b0;
    end else begin
      state       <= state_next;
      burst_valid <= burst_valid_next;
    end
  end

  `PMRBW_ASSERT_NOW(a_emit_in_run, cmd.emit, state == ST_RUN)
  `PMRBW_ASSERT_NOW(a_no_bubble, (state == ST_RUN) && !burst_valid, cmd.emit)
  `PMRBW_ASSERT_NEXT(a_last_ends, cmd.emit && sts.run_last, state == ST_IDLE)
  `PMRBW_ASSERT_NEXT(a_load_runs, cmd.load && sts.load_nonzero,
                     (state == ST_RUN) && !item_ready)

endmodule

// ----- design/pmrbw_dp.sv -----
`timescale 1ns / 1ps
module pmrbw_dp
  import pmrbw_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [MASK_W-1:0] channel_mask,
  input  logic [DUTY_W-1:0] duty_value,
  input  logic              cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        sts,
  output burst_t            desc
);

  logic [ADDR_W-1:0]  bus_addr;
  logic [COUNT_W-1:0] full_scale;
  logic [CHANNELS-1:0] rem;
  logic [COUNT_W-1:0]  on_c;
  logic [COUNT_W-1:0]  off_c;

  logic [CHANNELS-1:0] load_mask;
  logic [CHANNELS-1:0] low_bit;
  logic [CHANNELS:0]   carry_sum;
  logic [CHANNELS:0]   end_bit;
  logic [CHANNELS-1:0] rem_next;
  logic [FIRST_W-1:0]  first_idx;
  logic [RUN_W-1:0]    end_idx;
  logic [RUN_W-1:0]    run_len;
  logic [COUNT_W-1:0]  on_next;
  logic [COUNT_W-1:0]  off_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_addr   <= BUS_ADDR_RST;
      full_scale <= FULL_SCALE_RST;
    end else if (cfg_write) begin
      if (cfg_index == REG_BUS_ADDR) bus_addr <= cfg_data[ADDR_W-1:0];
      if (cfg_index == REG_FULL_SCALE) full_scale <= cfg_data[COUNT_W-1:0];
    end
  end

  // Map duty to the on/off pair
  always_comb begin
    on_next  = '0;
    off_next = COUNT_W'(duty_value >> 4);
    if (duty_value == DUTY_FULL_ON) begin
      on_next  = full_scale;
      off_next = '0;
    end else if (duty_value == DUTY_FULL_OFF) begin
      off_next = full_scale;
    end
  end

  assign load_mask        = channel_mask[CHANNELS-1:0];
  assign sts.load_nonzero = |load_mask;

  // Isolate the lowest run: adding its lowest bit carries through the run
  assign low_bit   = rem & (~rem + 1'b1);
  assign carry_sum = {1'b0, rem} + {1'b0, low_bit};
  assign end_bit   = carry_sum & ~{1'b0, rem};
  assign rem_next  = rem & carry_sum[CHANNELS-1:0];
  assign sts.run_last = (rem_next == '0);

  // Encode run start and end positions
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (low_bit[i]) first_idx = first_idx | FIRST_W'(i);
    end
  end

  always_comb begin
    end_idx = '0;
    for (int i = 0; i <= CHANNELS; i++) begin
      if (end_bit[i]) end_idx = end_idx | RUN_W'(i);
    end
  end

  assign run_len = end_idx - {1'b0, first_idx};

  // Load the mask, then retire one run per emit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem   <= load_mask;
      on_c  <= on_next;
      off_c <= off_next;
    end else if (cmd.emit) begin
      rem <= rem_next;
    end
  end

  // Output descriptor register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      desc.target_address <= bus_addr;
      desc.start_register <= FIRST_LED_REG + {1'b0, first_idx, 2'b00};
      desc.first_channel  <= first_idx;
      desc.run_length     <= run_len;
      desc.byte_count     <= {run_len, 2'b00};
      desc.on_count       <= on_c;
      desc.off_count      <= off_c;
      desc.last_burst     <= sts.run_last;
    end
  end

endmodule

// ----- design/pwm_mask_run_burst_writer.sv -----
`timescale 1ns / 1ps
// PWM channel-mask burst writer.
// item (sink): a channel mask and a 16-bit duty value. The duty becomes an
//   on/off count pair, and the mask is split from channel 0 upward into runs
//   of adjacent set bits.
// burst (source): one burst-write descriptor per run, lowest run first; the
//   final run of a mask carries last_burst. An empty mask gives no descriptor.
// cfg (sink): register 0 is the bus address, register 1 the full-scale count.
//   Always ready; write only while no mask is in progress.
// Timing: an accepted item loads the run finder, which then writes the first
//   descriptor into the output register; after that one descriptor per cycle
//   while burst.ready is high. The run finder retires one run per cycle while
//   the output register frees up.
// A new item is taken as soon as the last descriptor sits in the output
//   register, even while it still waits to be taken.
// Reset (rst, synchronous): clears the controller and output valid and
//   restores the configuration registers to address 64, full scale 4096.
// When the receiver stalls, the output register holds its descriptor and the
//   run finder waits.
module pwm_mask_run_burst_writer
  import pmrbw_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input logic        clk,
  input logic        rst,
  pmrbw_item_if.sink   item,
  pmrbw_burst_if.source burst,
  pmrbw_cfg_if.sink    cfg
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  burst_t     desc;

  assign cfg.ready = 1'b1;

  pmrbw_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item.valid),
    .item_ready  (item.ready),
    .burst_ready (burst.ready),
    .burst_valid (burst.valid),
    .cmd         (cmd),
    .sts         (sts)
  );

  pmrbw_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .channel_mask (item.channel_mask),
    .duty_value   (item.duty_value),
    .cfg_write    (cfg.valid && cfg.ready),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .cmd          (cmd),
    .sts          (sts),
    .desc         (desc)
  );

  assign burst.target_address = desc.target_address;
  assign burst.start_register = desc.start_register;
  assign burst.first_channel  = desc.first_channel;
  assign burst.run_length     = desc.run_length;
  assign burst.byte_count     = desc.byte_count;
  assign burst.on_count       = desc.on_count;
  assign burst.off_count      = desc.off_count;
  assign burst.last_burst     = desc.last_burst;

endmodule

// ----- test/tb_pwm_mask_run_burst_writer.sv -----
`timescale 1ns / 1ps
module tb_pwm_mask_run_burst_writer;
  import pmrbw_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 6;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 80;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk;
  logic rst;

  pmrbw_item_if  item_ch ();
  pmrbw_burst_if burst_ch ();
  pmrbw_cfg_if   cfg_ch ();

  pwm_mask_run_burst_writer #(
    .CHANNELS(CHANNELS_DEF)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .item (item_ch),
    .burst(burst_ch),
    .cfg  (cfg_ch)
  );

  // Shadow copy of the configuration registers
  logic [ADDR_W-1:0]  bus_addr_q;
  logic [COUNT_W-1:0] full_scale_q;

  burst_t expected_bursts[$];

  int error_count;
  int requests_sent;
  int bursts_checked;
  int cycle_count;
  int src_idle_pct;
  int sink_idle_pct;
  int hold_request;
  int hold_left;
  int stall_left;

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // Split the mask into runs and queue one descriptor per run
  function automatic void predict_bursts(input logic [MASK_W-1:0] mask,
                                         input logic [DUTY_W-1:0] duty);
    logic [COUNT_W-1:0] on_c;
    logic [COUNT_W-1:0] off_c;
    burst_t             desc;
    bit                 in_run;
    bit                 bit_set;
    int                 first;
    int                 runs;
    in_run = 1'b0;
    first  = 0;
    runs   = 0;
    if (duty == DUTY_FULL_ON) begin
      on_c  = full_scale_q;
      off_c = '0;
    end else if (duty == DUTY_FULL_OFF) begin
      on_c  = '0;
      off_c = full_scale_q;
    end else begin
      on_c  = '0;
      off_c = COUNT_W'(duty >> 4);
    end
    for (int ch = 0; ch <= CHANNELS_DEF; ch++) begin
      bit_set = (ch < CHANNELS_DEF) && mask[ch];
      if (bit_set && !in_run) begin
        in_run = 1'b1;
        first  = ch;
      end else if (!bit_set && in_run) begin
        in_run              = 1'b0;
        desc.target_address = bus_addr_q;
        desc.start_register = FIRST_LED_REG + REG_W'(4 * first);
        desc.first_channel  = FIRST_W'(first);
        desc.run_length     = RUN_W'(ch - first);
        desc.byte_count     = BYTES_W'(4 * (ch - first));
        desc.on_count       = on_c;
        desc.off_count      = off_c;
        desc.last_burst     = 1'b0;
        expected_bursts.push_back(desc);
        runs++;
      end
    end
    if (runs > 0) expected_bursts[expected_bursts.size() - 1].last_burst = 1'b1;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Compare each accepted descriptor with the oldest prediction
  always @(posedge clk) begin : check_burst
    burst_t want;
    if (!rst && burst_ch.valid && burst_ch.ready) begin
      if (expected_bursts.size() == 0) begin
        error_count++;
        $display("%0t: unexpected burst, expected none, actual first_channel %0d",
                 $time, burst_ch.first_channel);
      end else begin
        want = expected_bursts.pop_front();
        check_field("target_address", want.target_address, burst_ch.target_address);
        check_field("start_register", want.start_register, burst_ch.start_register);
        check_field("first_channel", want.first_channel, burst_ch.first_channel);
        check_field("run_length", want.run_length, burst_ch.run_length);
        check_field("byte_count", want.byte_count, burst_ch.byte_count);
        check_field("on_count", want.on_count, burst_ch.on_count);
        check_field("off_count", want.off_count, burst_ch.off_count);
        check_field("last_burst", want.last_burst, burst_ch.last_burst);
        bursts_checked++;
      end
    end
  end

  // Receiver: long hold-off on request, else random stall bursts
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      burst_ch.ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      burst_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      burst_ch.ready <= 1'b1;
      if ($urandom_range(0, 99) < sink_idle_pct) stall_left = $urandom_range(1, 18);
    end
  end

  // Offer one request and predict its bursts once it is taken
  task automatic send_item(input logic [MASK_W-1:0] mask, input logic [DUTY_W-1:0] duty);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < src_idle_pct) gap = $urandom_range(1, 18);
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.channel_mask <= mask;
    item_ch.duty_value   <= duty;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predict_bursts(mask, duty);
    requests_sent++;
  endtask

  // Drop valid, drain all predictions, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (expected_bursts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_BUS_ADDR:   bus_addr_q = value[ADDR_W-1:0];
      REG_FULL_SCALE: full_scale_q = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [MASK_W-1:0] random_mask();
    logic [31:0] ones;
    int          len;
    int          pos;
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return MASK_W'($urandom & $urandom);
      3, 4: return MASK_W'($urandom | $urandom);
      5: begin
        len  = $urandom_range(1, 16);
        pos  = $urandom_range(0, 15);
        ones = (32'd1 << len) - 32'd1;
        return MASK_W'(ones << pos);
      end
      default: return MASK_W'($urandom);
    endcase
  endfunction

  function automatic logic [DUTY_W-1:0] random_duty();
    case ($urandom_range(0, 7))
      0: return DUTY_FULL_OFF;
      1: return DUTY_FULL_ON;
      2: return DUTY_W'($urandom_range(1, 15));
      default: return DUTY_W'($urandom);
    endcase
  endfunction

  // Full on, full off and the shifted duty, including values that shift to zero
  task automatic test_duty_codes();
    send_item(16'h0001, DUTY_FULL_OFF);
    send_item(16'h0001, DUTY_FULL_ON);
    send_item(16'h0001, 16'h0001);
    send_item(16'h0001, 16'h000F);
    send_item(16'h0001, 16'h0010);
    send_item(16'h0001, 16'hFFFE);
    send_item(16'h0001, 16'h8000);
    settle();
  endtask

  // One full run, eight runs, edge channels and an empty mask
  task automatic test_mask_shapes();
    send_item(16'hFFFF, 16'h1234);
    send_item(16'h5555, 16'hABCD);
    send_item(16'hAAAA, 16'h5432);
    send_item(16'h8000, DUTY_FULL_ON);
    send_item(16'h0000, 16'h7777);
    send_item(16'h0001, 16'h00F0);
    send_item(16'h7FFE, DUTY_FULL_OFF);
    send_item(16'hF00F, 16'h0F0F);
    send_item(16'h1248, 16'hFFF0);
    send_item(16'h0000, DUTY_FULL_ON);
    settle();
  endtask

  // Register extremes, an address wider than seven bits and an unused index
  task automatic test_config_extremes();
    write_reg(REG_BUS_ADDR, '0);
    write_reg(REG_FULL_SCALE, '0);
    send_item(16'hFFFF, DUTY_FULL_ON);
    send_item(16'h5555, DUTY_FULL_OFF);
    settle();
    write_reg(REG_BUS_ADDR, 13'h1FFF);
    write_reg(REG_FULL_SCALE, 13'h1FFF);
    send_item(16'hFFFF, DUTY_FULL_ON);
    send_item(16'h0001, DUTY_FULL_OFF);
    send_item(16'h8001, 16'h1234);
    settle();
    write_reg(REG_UNUSED, 13'h0AAA);
    send_item(16'h0C30, DUTY_FULL_OFF);
    settle();
  endtask

  // Hold the receiver off while requests keep coming, so the input stalls
  task automatic test_back_pressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_request  = HOLD_CYCLES;
    for (int i = 0; i < 16; i++) send_item(16'h5555, random_duty());
    settle();
  endtask

  // Random requests over several register settings, calm in the last phase
  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_BUS_ADDR, CFG_DATA_W'($urandom));
          write_reg(REG_FULL_SCALE, CFG_DATA_W'($urandom));
        end
        1: begin
          write_reg(REG_BUS_ADDR, 13'd127);
          write_reg(REG_FULL_SCALE, 13'd4095);
        end
        2: begin
          write_reg(REG_BUS_ADDR, 13'd0);
          write_reg(REG_FULL_SCALE, 13'd1);
        end
        3: begin
          write_reg(REG_BUS_ADDR, CFG_DATA_W'($urandom_range(0, 127)));
          write_reg(REG_FULL_SCALE, 13'd8191);
        end
        default: begin
          write_reg(REG_BUS_ADDR, CFG_DATA_W'(BUS_ADDR_RST));
          write_reg(REG_FULL_SCALE, FULL_SCALE_RST);
        end
      endcase
      for (int i = 0; i < 74; i++) begin
        // alternate idle and busy stretches; none in the last phase
        if (phase == 4 || (i / 20) % 2 == 1) begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end else begin
          src_idle_pct  = 25;
          sink_idle_pct = 20;
        end
        send_item(random_mask(), random_duty());
      end
      settle();
    end
  endtask

  // Main sequence
  initial begin
    rst                  = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.channel_mask = '0;
    item_ch.duty_value   = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    burst_ch.ready       = 1'b0;
    bus_addr_q           = BUS_ADDR_RST;
    full_scale_q         = FULL_SCALE_RST;
    error_count          = 0;
    requests_sent        = 0;
    bursts_checked       = 0;
    cycle_count          = 0;
    src_idle_pct         = 20;
    sink_idle_pct        = 20;
    hold_request         = 0;
    hold_left            = 0;
    stall_left           = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_duty_codes();
    test_mask_shapes();
    test_config_extremes();
    src_idle_pct  = 20;
    sink_idle_pct = 20;
    test_back_pressure();
    test_random_traffic();

    if (expected_bursts.size() != 0) begin
      error_count++;
      $display("%0t: %0d bursts expected, actual none", $time, expected_bursts.size());
    end
    $display("Checked %0d burst descriptors from %0d requests", bursts_checked,
             requests_sent);
    $display("Covered duty codes, mask shapes, register extremes and back pressure");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
